>>> sv/garch11_volatility_estimator_defines.svh
// assertion macros for the garch volatility estimator checker
// no dependencies; included by files that hold concurrent assertions
`ifndef GARCH11_VOLATILITY_ESTIMATOR_DEFINES_SVH
`define GARCH11_VOLATILITY_ESTIMATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GARCH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GARCH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/garch_pkg.sv
// shared widths, reset values and register indexes of the garch volatility estimator
// no dependencies; used by every module of the block and by the checker
package garch_pkg;

  localparam int PRICE_W  = 24;
  localparam int CFG_W    = 32;
  localparam int WEIGHT_W = 16;
  localparam int VAR_W    = 64;
  localparam int SIGMA_W  = 32;
  localparam int MARKER_W = 12;

  localparam logic [CFG_W-1:0]    OMEGA_RESET  = 32'd0;
  localparam logic [WEIGHT_W-1:0] ALPHA_RESET  = 16'd3277;
  localparam logic [WEIGHT_W-1:0] BETA_RESET   = 16'd58982;
  localparam logic [MARKER_W-1:0] MARKER_LIMIT = 12'd2560;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_OMEGA = 2'd0,
    REG_ALPHA = 2'd1,
    REG_BETA  = 2'd2
  } cfg_reg_t;

endpackage

>>> sv/garch11_volatility_estimator.sv
// garch(1,1) volatility estimator over bar closing prices
// depends on garch_pkg and garch_isqrt
//
// usage: one closing price per transaction on the input channel (in_valid / in_ready).
// the first close after reset is only stored and gives no result; each later close
// gives one result transaction (sigma, marker_size) on the output channel
// (out_valid / out_ready). omega, alpha and beta are written on the cfg port
// (cfg_en, cfg_index, cfg_data); the user writes them only while the block is idle,
// as the block itself does not enforce it. in_ready is low while an item is in work,
// so a new close is taken only once the last one is handed to the output register.
// the work is done by one shared 32x32 multiplier used five times under the sequencer
// and by the 32-step square root.
// a stalled receiver holds the result in the output register; the next close is
// still accepted and worked on, and it waits only to hand over its own result.
// reset: omega 0, alpha 0.05, beta 0.9 (q0.16), no previous close, variance zero,
// output channel empty.
module garch11_volatility_estimator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_en,
  input  logic [1:0]                          cfg_index,
  input  logic [garch_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [garch_pkg::PRICE_W-1:0]       close_price,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [garch_pkg::SIGMA_W-1:0]       sigma,
  output logic [garch_pkg::MARKER_W-1:0]      marker_size
);

  localparam int VW = garch_pkg::VAR_W;
  localparam int SQ_W = 2 * garch_pkg::PRICE_W;
  localparam int MX_W = garch_pkg::SIGMA_W + 4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SEED, ST_MUL, ST_ACC, ST_SUM, ST_START, ST_ROOT, ST_OUT
  } state_t;

  state_t state;

  // configuration and state registers
  logic [garch_pkg::CFG_W-1:0]    omega;
  logic [garch_pkg::WEIGHT_W-1:0] alpha;
  logic [garch_pkg::WEIGHT_W-1:0] beta;
  logic [garch_pkg::PRICE_W-1:0]  previous_close;
  logic                           have_previous;
  logic [VW-1:0]                  variance;

  // working registers
  logic [garch_pkg::PRICE_W-1:0]  mag;
  logic [SQ_W-1:0]                sq;
  logic [1:0]                     k;
  logic [VW-1:0]                  prod;
  logic [VW-1:0]                  acc;
  logic [VW-1:0]                  pers;
  logic [garch_pkg::SIGMA_W-1:0]  root_r;

  logic [31:0]                    mul_a;
  logic [31:0]                    mul_b;
  logic [garch_pkg::PRICE_W-1:0]  diff;
  logic                           sq_start;
  logic                           sq_done;
  logic [garch_pkg::SIGMA_W-1:0]  sq_root;
  logic [MX_W-1:0]                sigma_x10;
  logic                           out_free;

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VW] ? {VW{1'b1}} : s[VW-1:0];
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign sq_start = (state == ST_START);
  assign out_free = !out_valid || out_ready;

  // absolute tick difference to the previous close
  assign diff = (close_price >= previous_close) ? (close_price - previous_close)
                                                : (previous_close - close_price);

  // ten times sigma, 36 bits wide
  assign sigma_x10 = {1'b0, root_r, 3'b000} + {3'b000, root_r, 1'b0};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = {8'd0, mag};
    mul_b = {8'd0, mag};
    if (state == ST_MUL) begin
      case (k)
        2'd0: begin
          mul_a = sq[31:0];
          mul_b = {16'd0, alpha};
        end
        2'd1: begin
          mul_a = {16'd0, sq[SQ_W-1:32]};
          mul_b = {16'd0, alpha};
        end
        2'd2: begin
          mul_a = variance[VW-1:32];
          mul_b = {16'd0, beta};
        end
        default: begin
          mul_a = variance[31:0];
          mul_b = {16'd0, beta};
        end
      endcase
    end
  end

  garch_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (variance),
    .done     (sq_done),
    .root     (sq_root)
  );

  // registered multiplier output
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      omega          <= garch_pkg::OMEGA_RESET;
      alpha          <= garch_pkg::ALPHA_RESET;
      beta           <= garch_pkg::BETA_RESET;
      previous_close <= '0;
      have_previous  <= 1'b0;
      variance       <= '0;
      out_valid      <= 1'b0;
      k              <= '0;
    end else begin
      // register writes
      if (cfg_en) begin
        case (cfg_index)
          garch_pkg::REG_OMEGA: omega <= cfg_data;
          garch_pkg::REG_ALPHA: alpha <= cfg_data[garch_pkg::WEIGHT_W-1:0];
          garch_pkg::REG_BETA:  beta  <= cfg_data[garch_pkg::WEIGHT_W-1:0];
          default: ;
        endcase
      end

      // output register empties on acceptance unless a new result loads
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            previous_close <= close_price;
            have_previous  <= 1'b1;
            mag            <= diff;
            if (have_previous) begin
              state <= ST_SQ;
            end
          end
        end
        // prod takes the squared difference
        ST_SQ: begin
          state <= ST_SEED;
        end
        // seed a zero variance with the squared shock
        ST_SEED: begin
          sq <= prod[SQ_W-1:0];
          if (variance == '0) begin
            variance <= {prod[SQ_W-1:0], 16'd0};
          end
          k     <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        // fold each partial product into shock or persistence
        ST_ACC: begin
          case (k)
            2'd0: acc <= prod;
            2'd1: acc <= acc + {prod[31:0], 32'd0};
            2'd2: begin
              pers <= {prod[SQ_W-1:0], 16'd0};
              acc  <= sat_add(acc, {32'd0, omega});
            end
            default: pers <= pers + {16'd0, prod[VW-1:16]};
          endcase
          if (k == 2'd3) begin
            state <= ST_SUM;
          end else begin
            k     <= k + 1'b1;
            state <= ST_MUL;
          end
        end
        ST_SUM: begin
          variance <= sat_add(acc, pers);
          state    <= ST_START;
        end
        ST_START: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sq_done) begin
            root_r <= sq_root;
            state  <= ST_OUT;
          end
        end
        // hand the result to the output register once it is free
        ST_OUT: begin
          if (out_free) begin
            sigma     <= root_r;
            marker_size <= (sigma_x10 > MX_W'(garch_pkg::MARKER_LIMIT))
                           ? garch_pkg::MARKER_LIMIT : sigma_x10[garch_pkg::MARKER_W-1:0];
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/garch_isqrt.sv
// iterative integer square root, two radicand bits per cycle
// depends on garch_pkg for the radicand and root widths
module garch_isqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [garch_pkg::VAR_W-1:0]      radicand,
  output logic                             done,
  output logic [garch_pkg::SIGMA_W-1:0]    root
);

  localparam int REM_W = garch_pkg::SIGMA_W + 2;
  localparam int TRY_W = garch_pkg::SIGMA_W + 4;
  localparam int CNT_W = $clog2(garch_pkg::SIGMA_W);

  logic [garch_pkg::VAR_W-1:0] val;
  logic [REM_W-1:0]            rem;
  logic [CNT_W-1:0]            cnt;
  logic                        run;

  logic [TRY_W-1:0] rem_sh;
  logic [TRY_W-1:0] trial;
  logic             ge;
  logic [TRY_W-1:0] rem_diff;

  // one restoring step: bring down two bits, try root*4+1
  always_comb begin
    rem_sh   = {rem, val[garch_pkg::VAR_W-1 -: 2]};
    trial    = {2'b00, root, 2'b01};
    ge       = (rem_sh >= trial);
    rem_diff = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      val  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
      run  <= 1'b1;
    end else if (run) begin
      val  <= {val[garch_pkg::VAR_W-3:0], 2'b00};
      rem  <= rem_diff[REM_W-1:0];
      root <= {root[garch_pkg::SIGMA_W-2:0], ge};
      cnt  <= cnt + 1'b1;
      if (cnt == CNT_W'(garch_pkg::SIGMA_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

>>> sv/garch_checker.sv
// port-level checks of the garch volatility estimator, bound to the top level
// depends on garch_pkg and garch11_volatility_estimator_defines.svh
`include "garch11_volatility_estimator_defines.svh"

module garch_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [garch_pkg::SIGMA_W-1:0]     sigma,
  input logic [garch_pkg::MARKER_W-1:0]    marker_size
);

  localparam int MX_W = garch_pkg::SIGMA_W + 4;

  logic [MX_W-1:0] sigma_x10;
  logic            marker_ok;

  // expected marker from the sigma shown beside it
  assign sigma_x10 = MX_W'(sigma) * MX_W'(10);
  assign marker_ok = (sigma_x10 > MX_W'(garch_pkg::MARKER_LIMIT))
                     ? (marker_size == garch_pkg::MARKER_LIMIT)
                     : (MX_W'(marker_size) == sigma_x10);

  `GARCH_ASSERT_IMP(a_marker_bound, clk, rst, out_valid, marker_size <= garch_pkg::MARKER_LIMIT, "marker size above limit")
  `GARCH_ASSERT_IMP(a_marker_match, clk, rst, out_valid, marker_ok, "marker size does not follow sigma")
  `GARCH_ASSERT_NXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sigma) && $stable(marker_size), "stalled result changed")
  `GARCH_ASSERT_NXT(a_input_hold, clk, rst, in_valid && !in_ready, in_valid, "input valid dropped before acceptance")
  `GARCH_ASSERT_IMP(a_reset_empty, clk, rst, $past(rst), !out_valid, "result valid right after reset")

endmodule

bind garch11_volatility_estimator garch_checker u_garch_checker (.*);
